>>> rtl/pfld_pkg.sv
`default_nettype none
package pfld_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int COORD_W     = 12;
  localparam int DELTA_W     = COORD_W + 1;
  localparam int ERR_W       = COORD_W + 2;
  localparam int IDX_W       = 12;
  localparam int DEF_WIDTH   = 128;
  localparam int DEF_HEIGHT  = 64;
  localparam int CFG_ADDR_W  = 3;

  localparam logic       REG_PEN_MODE = 1'b0;
  localparam logic [1:0] PEN_RESET    = 2'd1;

  typedef enum logic [1:0] {
    OP_LINE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PEN_CLEAR  = 2'd0,
    PEN_SET    = 2'd1,
    PEN_TOGGLE = 2'd2
  } pen_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_ORDER,
    ST_PIXEL,
    ST_MODIFY,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic order;
    logic step;
  } raster_cmd_t;

  typedef struct packed {
    logic              on;
    logic              last;
    logic [ADDR_W-1:0] idx;
    logic [7:0]        mask;
  } pix_info_t;

  function automatic logic [7:0] apply_pen(input logic [1:0] pen, input logic [7:0] data,
                                           input logic [7:0] mask);
    logic [7:0] res;
    res = data;
    unique case (pen)
      PEN_CLEAR:  res = data & ~mask;
      PEN_SET:    res = data | mask;
      PEN_TOGGLE: res = data ^ mask;
      default:    res = data;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/pfld_ram.sv
`default_nettype none
module pfld_ram (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [pfld_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]                 wr_data,
  input  wire logic                       rd_en,
  input  wire logic [pfld_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                      rd_data
);

  logic [7:0] mem [pfld_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/pfld_raster.sv
`default_nettype none
module pfld_raster #(
  parameter int DISPLAY_WIDTH  = pfld_pkg::DEF_WIDTH,
  parameter int DISPLAY_HEIGHT = pfld_pkg::DEF_HEIGHT
) (
  input  wire logic                                clk,
  input  wire pfld_pkg::raster_cmd_t               cmd,
  input  wire logic signed [pfld_pkg::COORD_W-1:0] x_start,
  input  wire logic signed [pfld_pkg::COORD_W-1:0] y_start,
  input  wire logic signed [pfld_pkg::COORD_W-1:0] x_end,
  input  wire logic signed [pfld_pkg::COORD_W-1:0] y_end,
  output pfld_pkg::pix_info_t                      pix
);

  localparam int CW = pfld_pkg::COORD_W;
  localparam int DW = pfld_pkg::DELTA_W;
  localparam int EW = pfld_pkg::ERR_W;
  localparam int IW = pfld_pkg::IDX_W;

  logic signed [CW-1:0] a0, b0, a1, b1;
  logic signed [CW-1:0] a, b;
  logic                 steep;
  logic                 ystep_neg;
  logic signed [EW-1:0] err;
  logic [DW-1:0]        dx, dy, remain;

  // setup: steepness and axis swap
  logic signed [DW-1:0] ddx, ddy;
  logic [DW-1:0]        adx, ady;
  logic                 steep_in;

  always_comb begin
    ddx      = {x_end[CW-1], x_end} - {x_start[CW-1], x_start};
    ddy      = {y_end[CW-1], y_end} - {y_start[CW-1], y_start};
    adx      = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
    ady      = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
    steep_in = ady > adx;
  end

  // order: endpoints by increasing major axis
  logic signed [CW-1:0] sa0, sb0, sa1, sb1;
  logic signed [DW-1:0] ddb;
  logic [DW-1:0]        dx_in, dy_in;

  always_comb begin
    if (a0 > a1) begin
      sa0 = a1; sb0 = b1; sa1 = a0; sb1 = b0;
    end else begin
      sa0 = a0; sb0 = b0; sa1 = a1; sb1 = b1;
    end
    dx_in = DW'({sa1[CW-1], sa1} - {sa0[CW-1], sa0});
    ddb   = {sb1[CW-1], sb1} - {sb0[CW-1], sb0};
    dy_in = ddb[DW-1] ? DW'(-ddb) : DW'(ddb);
  end

  // step
  logic signed [EW-1:0] err_dec;
  always_comb begin
    err_dec = err - $signed({1'b0, dy});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steep <= steep_in;
      a0    <= steep_in ? y_start : x_start;
      b0    <= steep_in ? x_start : y_start;
      a1    <= steep_in ? y_end : x_end;
      b1    <= steep_in ? x_end : y_end;
    end else if (cmd.order) begin
      a         <= sa0;
      b         <= sb0;
      dx        <= dx_in;
      dy        <= dy_in;
      remain    <= dx_in;
      err       <= $signed({1'b0, dx_in >> 1});
      ystep_neg <= !(sb0 < sb1);
    end else if (cmd.step) begin
      a      <= a + CW'(1);
      remain <= remain - DW'(1);
      if (err_dec[EW-1]) begin
        b   <= ystep_neg ? b - CW'(1) : b + CW'(1);
        err <= err_dec + $signed({1'b0, dx});
      end else begin
        err <= err_dec;
      end
    end
  end

  // pixel position and store location
  logic signed [CW-1:0] px, py;
  logic [IW-1:0]        idx_full;
  logic                 on_disp;

  always_comb begin
    px       = steep ? b : a;
    py       = steep ? a : b;
    on_disp  = !px[CW-1] && (px < CW'(DISPLAY_WIDTH)) &&
               !py[CW-1] && (py < CW'(DISPLAY_HEIGHT));
    idx_full = IW'(px[CW-2:0]) + IW'(py[CW-2:3]) * IW'(DISPLAY_WIDTH);
    pix.on   = on_disp && (idx_full < IW'(pfld_pkg::STORE_DEPTH));
    pix.last = remain == '0;
    pix.idx  = idx_full[pfld_pkg::ADDR_W-1:0];
    pix.mask = 8'(1) << py[2:0];
  end

endmodule
`default_nettype wire

>>> rtl/page_framebuffer_line_drawer_top.sv
// Flow: a read passes ST_READ and ST_READ_WAIT; a clear sweeps all 1024 store bytes in ST_CLEAR;
//   a draw passes ST_SETUP and ST_ORDER, then ST_PIXEL for each pixel and ST_MODIFY as well
//   for each pixel on the display (dx+1 pixels along the major axis); each then ends in ST_DONE
//   and the m_axis output register. Items are taken one at a time; each on-screen pixel is a
//   read-modify-write on the single-port-read frame store, which sets the draw rate.
// Reset: pen_mode returns to set; a sweep zeroes all 1024 store bytes, tready low meanwhile.
`default_nettype none
module page_framebuffer_line_drawer_top #(
  parameter int DISPLAY_WIDTH  = pfld_pkg::DEF_WIDTH,
  parameter int DISPLAY_HEIGHT = pfld_pkg::DEF_HEIGHT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // APB
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pfld_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // input words
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [63:0]                     s_axis_tdata, // x_start, y_start, x_end, y_end, byte_address
  input  wire logic [1:0]                      s_axis_tuser, // operation
  // result words
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata  // read_data
);

  localparam int AW = pfld_pkg::ADDR_W;
  localparam int CW = pfld_pkg::COORD_W;

  pfld_pkg::state_t state, state_next;

  logic [1:0]           pen_mode;
  logic [AW-1:0]        clr_cnt;
  logic                 clr_reply;
  logic [7:0]           result;
  logic [1:0]           op;
  logic signed [CW-1:0] x_start, y_start, x_end, y_end;
  logic [AW-1:0]        byte_address;

  pfld_pkg::raster_cmd_t cmd;
  pfld_pkg::pix_info_t   pix;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  logic in_acc, out_free, clr_last;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == pfld_pkg::REG_PEN_MODE) ? {30'd0, pen_mode} : 32'd0;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign clr_last = clr_cnt == AW'(pfld_pkg::STORE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_mode <= pfld_pkg::PEN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == pfld_pkg::REG_PEN_MODE) begin
      pen_mode <= pwdata[1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfld_pkg::ST_CLEAR: begin
        if (clr_last) state_next = clr_reply ? pfld_pkg::ST_DONE : pfld_pkg::ST_IDLE;
      end
      pfld_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (s_axis_tuser)
            pfld_pkg::OP_LINE:  state_next = pfld_pkg::ST_SETUP;
            pfld_pkg::OP_READ:  state_next = pfld_pkg::ST_READ;
            pfld_pkg::OP_CLEAR: state_next = pfld_pkg::ST_CLEAR;
            default:            state_next = pfld_pkg::ST_DONE;
          endcase
        end
      end
      pfld_pkg::ST_SETUP:     state_next = pfld_pkg::ST_ORDER;
      pfld_pkg::ST_ORDER:     state_next = pfld_pkg::ST_PIXEL;
      pfld_pkg::ST_PIXEL: begin
        priority if (pix.on) state_next = pfld_pkg::ST_MODIFY;
        else if (pix.last)   state_next = pfld_pkg::ST_DONE;
        else                 state_next = pfld_pkg::ST_PIXEL;
      end
      pfld_pkg::ST_MODIFY: begin
        state_next = pix.last ? pfld_pkg::ST_DONE : pfld_pkg::ST_PIXEL;
      end
      pfld_pkg::ST_READ:      state_next = pfld_pkg::ST_READ_WAIT;
      pfld_pkg::ST_READ_WAIT: state_next = pfld_pkg::ST_DONE;
      pfld_pkg::ST_DONE: begin
        if (out_free) state_next = pfld_pkg::ST_IDLE;
      end
      default:                state_next = pfld_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    wr_en         = 1'b0;
    wr_addr       = pix.idx;
    wr_data       = pfld_pkg::apply_pen(pen_mode, rd_data, pix.mask);
    rd_en         = 1'b0;
    rd_addr       = pix.idx;
    unique case (state)
      pfld_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = 8'd0;
      end
      pfld_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      pfld_pkg::ST_SETUP: cmd.load = 1'b1;
      pfld_pkg::ST_ORDER: cmd.order = 1'b1;
      pfld_pkg::ST_PIXEL: begin
        rd_en    = pix.on;
        cmd.step = !pix.on && !pix.last;
      end
      pfld_pkg::ST_MODIFY: begin
        wr_en    = 1'b1;
        cmd.step = !pix.last;
      end
      pfld_pkg::ST_READ: begin
        rd_en   = 1'b1;
        rd_addr = byte_address;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pfld_pkg::ST_CLEAR;
      clr_cnt       <= '0;
      clr_reply     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pfld_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (in_acc) begin
        clr_reply <= s_axis_tuser == pfld_pkg::OP_CLEAR;
      end
      if (state == pfld_pkg::ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op           <= s_axis_tuser;
      x_start      <= s_axis_tdata[11:0];
      y_start      <= s_axis_tdata[23:12];
      x_end        <= s_axis_tdata[35:24];
      y_end        <= s_axis_tdata[47:36];
      byte_address <= s_axis_tdata[57:48];
      result       <= 8'd0;
    end else if (state == pfld_pkg::ST_READ_WAIT && op == pfld_pkg::OP_READ) begin
      result <= rd_data;
    end
    if (state == pfld_pkg::ST_DONE && out_free) begin
      m_axis_tdata <= result;
    end
  end

  pfld_raster #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_raster (
    .clk     (clk),
    .cmd     (cmd),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .pix     (pix)
  );

  pfld_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire
